/* hw/rtl/running_top_k_minimum_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the running top-k minimum core
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RUNNING_TOP_K_MINIMUM_CORE_MACROS_SVH
`define RUNNING_TOP_K_MINIMUM_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTKM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTKM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rtkm_pkg.sv */
// ---------------------------------------------------------------------------
// rtkm_pkg
// Widths, register codes, the step control struct and the limit helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtkm_pkg;

    localparam int MAX_KEPT     = 16;
    localparam int SCORE_BITS   = 16;
    localparam int LIMIT_BITS   = 5;
    localparam int COUNT_BITS   = $clog2(MAX_KEPT + 1);
    localparam int GROW_BITS    = COUNT_BITS + 1;
    localparam int IDX_BITS     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int APB_DATA     = 32;
    localparam int PADDR_BITS   = 3;
    localparam int REG_IDX_BITS = 1;

    localparam logic [REG_IDX_BITS-1:0] REG_KEEP_LIMIT = 1'b0;
    localparam logic [LIMIT_BITS-1:0]   KEEP_LIMIT_RESET = 5'd16;

    // Control for one insert step.
    typedef struct packed {
        logic fire;
        logic start;
    } rtkm_step_t;

    // A limit of zero acts as one; a limit above the capacity saturates.
    function automatic logic [COUNT_BITS-1:0] eff_limit(input logic [LIMIT_BITS-1:0] limit);
        int k;
        k = int'(limit);
        if (k == 0) begin
            k = 1;
        end
        if (k > MAX_KEPT) begin
            k = MAX_KEPT;
        end
        return COUNT_BITS'(k);
    endfunction

endpackage

/* hw/rtl/running_top_k_minimum_core.sv */
// A score accepted into the input register is inserted, and its result loaded into the
// result register, once that register is free or being emptied.
// Throughput: one score per cycle while the result channel does not stall, set by the
// compare-and-shift insert over the sixteen kept-score registers.
// Reset clears the kept count, both valid flags and sets keep_limit to 16.
// ---------------------------------------------------------------------------
// running_top_k_minimum_core
// Streaming top-k selection reporting the k-th largest score seen so far.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "running_top_k_minimum_core_macros.svh"

module running_top_k_minimum_core
    import rtkm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input channel
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [SCORE_BITS-1:0] score,
    input  logic                  start_req,
    // Result channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [SCORE_BITS-1:0] kth_largest,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [APB_DATA-1:0]   pwdata,
    output logic [APB_DATA-1:0]   prdata,
    output logic                  pready
);

    // The design is a two-register pipeline. The input register holds one
    // accepted score; the insert logic reads it together with the kept-score
    // registers and, when the result register is free or being emptied in the
    // same cycle, updates the kept scores and loads the result register in
    // one step. The result register decouples the two sides, so a new score
    // can enter an empty input register while a finished result still waits downstream.

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [SCORE_BITS-1:0] score_reg;
    logic                  start_reg;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    logic [SCORE_BITS-1:0] kth_reg;
    logic                  accept;
    logic                  advance;
    rtkm_step_t            step;
    logic [SCORE_BITS-1:0] min_next;
    logic [COUNT_BITS-1:0] kept_count;
    logic [LIMIT_BITS-1:0] keep_limit;
    logic [COUNT_BITS-1:0] limit_now;

    // The held item moves on whenever the result register can take it.
    assign advance    = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign step.fire  = advance;
    assign step.start = start_reg;

    // The limit in force, as the insert logic sees it.
    assign limit_now  = eff_limit(keep_limit);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg && result_stall;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            score_reg <= score;
            start_reg <= start_req;
        end
        if (advance)
        begin
            kth_reg <= min_next;
        end
    end

    rtkm_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .keep_limit (keep_limit)
    );

    rtkm_sorted_array u_array (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .score      (score_reg),
        .keep_limit (keep_limit),
        .min_next   (min_next),
        .kept_count (kept_count)
    );

    assign result_valid = result_valid_reg;
    assign kth_largest  = kth_reg;

    // A stall towards the source only ever comes from a held item.
    `RTKM_ASSERT_SAME(a_stall_needs_item, item_stall, s1_valid_reg, "stall without a held item")
    // Every delivered result comes from a non-empty kept set.
    `RTKM_ASSERT_SAME(a_result_has_kept, result_valid_reg, kept_count != '0, "result with empty set")
    // After a step the kept set never exceeds the limit in force.
    `RTKM_ASSERT_NEXT(a_count_limit, advance, kept_count <= $past(limit_now), "count over limit")

endmodule

/* hw/rtl/rtkm_apb_regs.sv */
// ---------------------------------------------------------------------------
// rtkm_apb_regs
// Configuration register file behind a simple APB-style port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtkm_apb_regs
    import rtkm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [APB_DATA-1:0]   pwdata,
    output logic [APB_DATA-1:0]   prdata,
    output logic                  pready,
    output logic [LIMIT_BITS-1:0] keep_limit
);

    logic [LIMIT_BITS-1:0]   keep_limit_reg;
    logic [LIMIT_BITS-1:0]   keep_limit_next;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:PADDR_BITS-REG_IDX_BITS];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        keep_limit_next = keep_limit_reg;
        prdata          = '0;
        unique case (reg_idx)
            REG_KEEP_LIMIT:
            begin
                prdata = APB_DATA'(keep_limit_reg);
                if (wr_en)
                begin
                    keep_limit_next = pwdata[LIMIT_BITS-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_limit_reg <= KEEP_LIMIT_RESET;
        end
        else
        begin
            keep_limit_reg <= keep_limit_next;
        end
    end

    assign keep_limit = keep_limit_reg;

endmodule

/* hw/rtl/rtkm_sorted_array.sv */
// ---------------------------------------------------------------------------
// rtkm_sorted_array
// Kept scores in descending order with a parallel compare-and-shift insert.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtkm_sorted_array
    import rtkm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtkm_step_t            step,
    input  logic [SCORE_BITS-1:0] score,
    input  logic [LIMIT_BITS-1:0] keep_limit,
    output logic [SCORE_BITS-1:0] min_next,
    output logic [COUNT_BITS-1:0] kept_count
);

    logic [SCORE_BITS-1:0] kept_reg  [MAX_KEPT];
    logic [SCORE_BITS-1:0] kept_next [MAX_KEPT];
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_base;
    logic [COUNT_BITS-1:0] limit_eff;
    logic [GROW_BITS-1:0]  count_grown;
    logic [MAX_KEPT-1:0]   stay;
    logic [IDX_BITS-1:0]   rd_idx;

    assign limit_eff = eff_limit(keep_limit);

    // Entries that stay in place are the valid ones not below the new score;
    // they form a prefix because the array is sorted largest first.
    always_comb
    begin
        for (int i = 0; i < MAX_KEPT; i++)
        begin
            stay[i] = !step.start && (COUNT_BITS'(i) < count_reg) && (kept_reg[i] >= score);
        end
        kept_next[0] = stay[0] ? kept_reg[0] : score;
        for (int i = 1; i < MAX_KEPT; i++)
        begin
            if (stay[i])
            begin
                kept_next[i] = kept_reg[i];
            end
            else if (stay[i-1])
            begin
                kept_next[i] = score;
            end
            else
            begin
                kept_next[i] = kept_reg[i-1];
            end
        end
    end

    // Dropping the smallest entries is just a shorter count.
    always_comb
    begin
        count_base  = step.start ? '0 : count_reg;
        count_grown = GROW_BITS'(count_base) + GROW_BITS'(1);
        if (count_grown > GROW_BITS'(limit_eff))
        begin
            count_next = limit_eff;
        end
        else
        begin
            count_next = count_grown[COUNT_BITS-1:0];
        end
        rd_idx   = IDX_BITS'(count_next - COUNT_BITS'(1));
        min_next = kept_next[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step.fire)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.fire)
        begin
            for (int i = 0; i < MAX_KEPT; i++)
            begin
                kept_reg[i] <= kept_next[i];
            end
        end
    end

    assign kept_count = count_reg;

endmodule
